// File: hdl/tcu_pkg.sv
package tcu_pkg;

    localparam int USER_ID_W   = 10;
    localparam int ITEM_ID_W   = 8;
    localparam int OUT_COUNT_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_LABELS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ON_EVAL = 2'd2;

    localparam logic [1:0] MODE_NORMAL    = 2'd0;
    localparam logic [1:0] MODE_INVERTED  = 2'd1;
    localparam logic [1:0] MODE_SYMMETRIC = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_USER,
        S_FWD,
        S_INV
    } t_state;

endpackage

// File: hdl/tcu_if.sv
interface tcu_in_if
    import tcu_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [USER_ID_W-1:0] user_id;
    logic [ITEM_ID_W-1:0] item_id;
    logic [ITEM_ID_W-1:0] item_label;
    logic                 eval_flag;

    modport source (output valid, user_id, item_id, item_label, eval_flag, input ready);
    modport sink   (input valid, user_id, item_id, item_label, eval_flag, output ready);
endinterface

interface tcu_out_if
    import tcu_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   first_seen;
    logic                   forward_done;
    logic [OUT_COUNT_W-1:0] forward_count;
    logic                   inverse_done;
    logic [OUT_COUNT_W-1:0] inverse_count;

    modport source (output valid, first_seen, forward_done, forward_count, inverse_done,
                    inverse_count, input ready);
    modport sink   (input valid, first_seen, forward_done, forward_count, inverse_done,
                    inverse_count, output ready);
endinterface

interface tcu_cfg_if
    import tcu_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/transition_count_updater.sv
// Flow: an accepted event first reads its user entry; each bumped direction then adds
//   a count update step (S_FWD, S_INV) before the result is registered, and a full
//   output register stalls the last step. Events are taken one at a time: a new one
//   is accepted only in idle or in the final count update step of the previous event.
// Reset: a clearing pass zeroes all NUM_USERS user entries and 2**(2*clog2(NUM_ITEMS))
//   count cells (65536 at default) and holds off events; config registers reset to 0.
module transition_count_updater
    import tcu_pkg::*;
#(
    parameter int NUM_USERS   = 1024,
    parameter int NUM_ITEMS   = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcu_cfg_if.sink     i_cfg,
    tcu_in_if.sink      i_evt,
    tcu_out_if.source   o_res
);

    localparam int UW        = $clog2(NUM_USERS);
    localparam int IW        = $clog2(NUM_ITEMS);
    localparam int CAW       = 2 * IW;
    localparam int CNT_DEPTH = 1 << CAW;
    localparam int UE_W      = 1 + 2 * IW;
    localparam int CLR_LEN   = (NUM_USERS > CNT_DEPTH) ? NUM_USERS : CNT_DEPTH;
    localparam int CLR_W     = $clog2(CLR_LEN);
    localparam logic [CLR_W:0]   CLR_USERS = (CLR_W+1)'(NUM_USERS);
    localparam logic [CLR_W:0]   CLR_CNTS  = (CLR_W+1)'(CNT_DEPTH);
    localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_LEN - 1);

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    t_state r_state, n_state;

    logic [1:0]       r_cfg_mode;
    logic             r_cfg_labels;
    logic             r_cfg_filter;
    logic [CLR_W-1:0] r_clr;

    logic [UE_W-1:0]        r_umem [NUM_USERS];
    logic [UE_W-1:0]        r_urd;
    logic [COUNT_WIDTH-1:0] r_cmem [CNT_DEPTH];
    logic [COUNT_WIDTH-1:0] r_crd;

    logic [IW-1:0]          r_item;
    logic [IW-1:0]          r_entity;
    logic [UW-1:0]          r_user;
    logic                   r_eval;
    logic                   r_fwd_en;
    logic                   r_inv_en;
    logic                   r_same;
    logic [CAW-1:0]         r_fwd_addr;
    logic [CAW-1:0]         r_inv_addr;
    logic [COUNT_WIDTH-1:0] r_fwd_cnt;

    logic                   r_out_valid;
    logic                   r_o_first;
    logic                   r_o_fwd_done;
    logic [OUT_COUNT_W-1:0] r_o_fwd_cnt;
    logic                   r_o_inv_done;
    logic [OUT_COUNT_W-1:0] r_o_inv_cnt;

    logic [UW-1:0] w_user;
    logic [IW-1:0] w_item;
    logic [IW-1:0] w_label;

    logic                   in_ready, out_free, accept, load_out, start_cnt, save_fwd;
    logic                   u_re, u_we, c_re, c_we;
    logic [UW-1:0]          u_ra, u_wa;
    logic [UE_W-1:0]        u_wd;
    logic [CAW-1:0]         c_ra, c_wa;
    logic [COUNT_WIDTH-1:0] c_wd;
    logic                   n_o_first, n_o_fwd_done, n_o_inv_done;
    logic [OUT_COUNT_W-1:0] n_o_fwd_cnt, n_o_inv_cnt;

    logic                   u_seen, bump_ok, fwd_req, inv_req;
    logic [IW-1:0]          u_le, u_li;
    logic [CAW-1:0]         fwd_addr, inv_addr;
    logic [COUNT_WIDTH-1:0] fwd_inc, inv_inc;
    logic                   clr_u, clr_c;

    tcu_wrap #(.IN_W(USER_ID_W), .MOD(NUM_USERS), .OUT_W(UW)) u_wrap_user (
        .i_val (i_evt.user_id),
        .o_val (w_user)
    );

    tcu_wrap #(.IN_W(ITEM_ID_W), .MOD(NUM_ITEMS), .OUT_W(IW)) u_wrap_item (
        .i_val (i_evt.item_id),
        .o_val (w_item)
    );

    tcu_wrap #(.IN_W(ITEM_ID_W), .MOD(NUM_ITEMS), .OUT_W(IW)) u_wrap_label (
        .i_val (i_evt.item_label),
        .o_val (w_label)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode   <= MODE_NORMAL;
            r_cfg_labels <= 1'b0;
            r_cfg_filter <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_COUNT_MODE:     r_cfg_mode   <= i_cfg.data[1:0];
                REG_USE_LABELS:     r_cfg_labels <= i_cfg.data[0];
                REG_FILTER_ON_EVAL: r_cfg_filter <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign u_seen   = r_urd[UE_W-1];
    assign u_le     = r_urd[2*IW-1:IW];
    assign u_li     = r_urd[IW-1:0];
    assign bump_ok  = u_seen && (!r_cfg_filter || r_eval);
    assign fwd_req  = bump_ok && (r_cfg_mode == MODE_NORMAL || r_cfg_mode == MODE_SYMMETRIC);
    assign inv_req  = bump_ok && (r_cfg_mode == MODE_INVERTED || r_cfg_mode == MODE_SYMMETRIC);
    assign fwd_addr = {u_le, r_item};
    assign inv_addr = {r_entity, r_cfg_labels ? u_li : u_le};
    assign fwd_inc  = sat_inc(r_crd);
    assign inv_inc  = sat_inc(r_same ? r_fwd_cnt : r_crd);
    assign out_free = !r_out_valid || o_res.ready;
    assign clr_u    = {1'b0, r_clr} < CLR_USERS;
    assign clr_c    = {1'b0, r_clr} < CLR_CNTS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        in_ready     = 1'b0;
        load_out     = 1'b0;
        start_cnt    = 1'b0;
        save_fwd     = 1'b0;
        u_re         = 1'b0;
        u_ra         = w_user;
        u_we         = 1'b0;
        u_wa         = r_user;
        u_wd         = {1'b1, r_entity, r_item};
        c_re         = 1'b0;
        c_ra         = fwd_req ? fwd_addr : inv_addr;
        c_we         = 1'b0;
        c_wa         = r_fwd_addr;
        c_wd         = fwd_inc;
        n_o_first    = 1'b0;
        n_o_fwd_done = 1'b0;
        n_o_fwd_cnt  = '0;
        n_o_inv_done = 1'b0;
        n_o_inv_cnt  = '0;

        unique case (r_state)
            S_CLEAR: begin
                u_we = clr_u;
                u_wa = r_clr[UW-1:0];
                u_wd = '0;
                c_we = clr_c;
                c_wa = r_clr[CAW-1:0];
                c_wd = '0;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_USER: begin
                if (fwd_req || inv_req) begin
                    u_we      = 1'b1;
                    c_re      = 1'b1;
                    start_cnt = 1'b1;
                    n_state   = fwd_req ? S_FWD : S_INV;
                end else if (out_free) begin
                    u_we      = 1'b1;
                    load_out  = 1'b1;
                    n_o_first = !u_seen;
                    n_state   = S_IDLE;
                end
            end
            S_FWD: begin
                if (r_inv_en) begin
                    c_we     = 1'b1;
                    c_re     = 1'b1;
                    c_ra     = r_inv_addr;
                    save_fwd = 1'b1;
                    n_state  = S_INV;
                end else if (out_free) begin
                    in_ready     = 1'b1;
                    c_we         = 1'b1;
                    load_out     = 1'b1;
                    n_o_fwd_done = 1'b1;
                    n_o_fwd_cnt  = OUT_COUNT_W'(fwd_inc);
                    n_state      = S_IDLE;
                end
            end
            S_INV: begin
                if (out_free) begin
                    in_ready     = 1'b1;
                    c_we         = 1'b1;
                    c_wa         = r_inv_addr;
                    c_wd         = inv_inc;
                    load_out     = 1'b1;
                    n_o_fwd_done = r_fwd_en;
                    n_o_fwd_cnt  = r_fwd_en ? OUT_COUNT_W'(r_fwd_cnt) : '0;
                    n_o_inv_done = 1'b1;
                    n_o_inv_cnt  = OUT_COUNT_W'(inv_inc);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        if (in_ready && i_evt.valid) begin
            u_re    = 1'b1;
            n_state = S_USER;
        end
    end

    assign accept      = in_ready && i_evt.valid;
    assign i_evt.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (u_we) begin
            r_umem[u_wa] <= u_wd;
        end
        if (u_re) begin
            r_urd <= r_umem[u_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cmem[c_wa] <= c_wd;
        end
        if (c_re) begin
            r_crd <= r_cmem[c_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_user   <= w_user;
            r_item   <= w_item;
            r_entity <= r_cfg_labels ? w_label : w_item;
            r_eval   <= i_evt.eval_flag;
        end
        if (start_cnt) begin
            r_fwd_addr <= fwd_addr;
            r_inv_addr <= inv_addr;
        end
        if (save_fwd) begin
            r_fwd_cnt <= fwd_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_en <= 1'b0;
            r_inv_en <= 1'b0;
            r_same   <= 1'b0;
        end else if (start_cnt) begin
            r_fwd_en <= fwd_req;
            r_inv_en <= inv_req;
            r_same   <= fwd_req && inv_req && (fwd_addr == inv_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_first    <= n_o_first;
            r_o_fwd_done <= n_o_fwd_done;
            r_o_fwd_cnt  <= n_o_fwd_cnt;
            r_o_inv_done <= n_o_inv_done;
            r_o_inv_cnt  <= n_o_inv_cnt;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.first_seen    = r_o_first;
    assign o_res.forward_done  = r_o_fwd_done;
    assign o_res.forward_count = r_o_fwd_cnt;
    assign o_res.inverse_done  = r_o_inv_done;
    assign o_res.inverse_count = r_o_inv_cnt;

    a_same_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_same |-> (r_fwd_en && r_inv_en))
        else $error("same-cell forward without both directions");

    a_inv_state_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INV) |-> r_inv_en)
        else $error("inverse stage entered without inverse bump");

    a_fwd_then_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FWD) && r_inv_en) |=> (r_state == S_INV))
        else $error("symmetric event skipped inverse bump");

    a_dual_write_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (u_we && c_we) |-> (r_state == S_CLEAR))
        else $error("user and count memories written together outside clear");

    a_accept_to_user: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready) |=> (r_state == S_USER))
        else $error("accepted beat did not start user lookup");

endmodule

// File: hdl/tcu_wrap.sv
module tcu_wrap #(
    parameter int IN_W  = 8,
    parameter int MOD   = 256,
    parameter int OUT_W = $clog2(MOD)
) (
    input  logic [IN_W-1:0]  i_val,
    output logic [OUT_W-1:0] o_val
);

    generate
        if (MOD >= (1 << IN_W)) begin : g_pass
            assign o_val = OUT_W'(i_val);
        end else begin : g_reduce
            localparam int          TOP_K = IN_W - $clog2(MOD);
            localparam logic [IN_W-1:0] MOD_V = IN_W'(MOD);

            always_comb begin
                logic [IN_W-1:0] rem;
                logic [IN_W-1:0] sub;
                rem = i_val;
                for (int k = TOP_K; k >= 0; k--) begin
                    sub = MOD_V << k;
                    if (rem >= sub) begin
                        rem = rem - sub;
                    end
                end
                o_val = OUT_W'(rem);
            end
        end
    endgenerate

endmodule

// File: tb/transition_count_updater_tb.sv
`timescale 1ns / 1ps

module transition_count_updater_tb;
    import tcu_pkg::*;

    localparam int N_USERS     = 1024;
    localparam int N_ITEMS     = 256;
    localparam int N_PHASES    = 9;
    localparam int PHASE_BEATS = 70;
    localparam int HOLD_CYCLES = 150;
    localparam int PRESS_PHASE = 6;
    localparam int PRINT_CAP   = 40;

    localparam logic [1:0] MODE_RECORD_ONLY = 2'd3;

    localparam logic [1:0] PHASE_MODE [N_PHASES] = '{
        MODE_NORMAL, MODE_INVERTED, MODE_SYMMETRIC, MODE_RECORD_ONLY, MODE_SYMMETRIC,
        MODE_NORMAL, MODE_SYMMETRIC, MODE_INVERTED, MODE_SYMMETRIC
    };
    localparam bit PHASE_LABELS [N_PHASES] = '{
        1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1
    };
    localparam bit PHASE_FILTER [N_PHASES] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1
    };

    typedef struct packed {
        logic [USER_ID_W-1:0] user_id;
        logic [ITEM_ID_W-1:0] item_id;
        logic [ITEM_ID_W-1:0] item_label;
        logic                 eval_flag;
    } t_visit;

    typedef struct packed {
        logic                   first_seen;
        logic                   forward_done;
        logic [OUT_COUNT_W-1:0] forward_count;
        logic                   inverse_done;
        logic [OUT_COUNT_W-1:0] inverse_count;
    } t_update;

    class t_transition_ledger;
        logic [1:0]           mode;
        logic                 labels_on;
        logic                 eval_filter;
        bit                   user_seen [N_USERS];
        logic [ITEM_ID_W-1:0] prev_entity [N_USERS];
        logic [ITEM_ID_W-1:0] prev_item [N_USERS];
        bit [OUT_COUNT_W-1:0] counts [N_ITEMS*N_ITEMS];
        t_update              pending [$];

        function new();
            mode        = MODE_NORMAL;
            labels_on   = 1'b0;
            eval_filter = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_COUNT_MODE:     mode = val;
                REG_USE_LABELS:     labels_on = val[0];
                REG_FILTER_ON_EVAL: eval_filter = val[0];
                default: ;
            endcase
        endfunction

        // saturate at all ones
        function logic [OUT_COUNT_W-1:0] bump(logic [ITEM_ID_W-1:0] from,
                                              logic [ITEM_ID_W-1:0] to);
            if (counts[{from, to}] != '1)
                counts[{from, to}] = counts[{from, to}] + 1'b1;
            return counts[{from, to}];
        endfunction

        function void note_visit(t_visit v);
            logic [ITEM_ID_W-1:0] entity;
            logic [ITEM_ID_W-1:0] prior;
            t_update              u;
            entity = labels_on ? v.item_label : v.item_id;
            u = '0;
            if (!user_seen[v.user_id]) begin
                user_seen[v.user_id] = 1'b1;
                u.first_seen = 1'b1;
            end else if (!eval_filter || v.eval_flag) begin
                if (mode == MODE_NORMAL || mode == MODE_SYMMETRIC) begin
                    u.forward_done  = 1'b1;
                    u.forward_count = bump(prev_entity[v.user_id], v.item_id);
                end
                if (mode == MODE_INVERTED || mode == MODE_SYMMETRIC) begin
                    prior = labels_on ? prev_item[v.user_id] : prev_entity[v.user_id];
                    u.inverse_done  = 1'b1;
                    u.inverse_count = bump(entity, prior);
                end
            end
            prev_entity[v.user_id] = entity;
            prev_item[v.user_id]   = v.item_id;
            pending.push_back(u);
        endfunction

        function bit check_update(t_update got, output string msg);
            t_update want;
            if (pending.size() == 0) begin
                msg = $sformatf("result beat with nothing outstanding: fwd %0d inv %0d",
                                got.forward_count, got.inverse_count);
                return 1'b0;
            end
            want = pending.pop_front();
            msg = "";
            if (got.first_seen !== want.first_seen)
                msg = {msg, $sformatf(" first_seen %b exp %b", got.first_seen,
                                      want.first_seen)};
            if (got.forward_done !== want.forward_done)
                msg = {msg, $sformatf(" forward_done %b exp %b", got.forward_done,
                                      want.forward_done)};
            if (got.forward_count !== want.forward_count)
                msg = {msg, $sformatf(" forward_count %0d exp %0d", got.forward_count,
                                      want.forward_count)};
            if (got.inverse_done !== want.inverse_done)
                msg = {msg, $sformatf(" inverse_done %b exp %b", got.inverse_done,
                                      want.inverse_done)};
            if (got.inverse_count !== want.inverse_count)
                msg = {msg, $sformatf(" inverse_count %0d exp %0d", got.inverse_count,
                                      want.inverse_count)};
            if (msg != "")
                msg = {"result beat:", msg};
            return msg == "";
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tcu_cfg_if cfg_bus ();
    tcu_in_if  evt_bus ();
    tcu_out_if res_bus ();

    transition_count_updater dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_evt   (evt_bus),
        .o_res   (res_bus)
    );

    t_transition_ledger ledger;
    int                 mismatches;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    bit                 hold_request;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic wait_drained();
        while (ledger.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic labels,
                                  input logic filter);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = REG_COUNT_MODE;
        val[0] = mode;
        idx[1] = REG_USE_LABELS;
        val[1] = {1'b0, labels};
        idx[2] = REG_FILTER_ON_EVAL;
        val[2] = {1'b0, filter};
        for (int k = 0; k < 3; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[k];
            cfg_bus.data  <= val[k];
            do @(posedge i_clk); while (!cfg_bus.ready);
            ledger.set_register(idx[k], val[k]);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_visit(input t_visit v);
        evt_bus.valid      <= 1'b1;
        evt_bus.user_id    <= v.user_id;
        evt_bus.item_id    <= v.item_id;
        evt_bus.item_label <= v.item_label;
        evt_bus.eval_flag  <= v.eval_flag;
        do @(posedge i_clk); while (!evt_bus.ready);
        ledger.note_visit(v);
        if ($urandom_range(99) < src_idle_pct) begin
            evt_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    initial begin : result_sink
        t_update got;
        string   msg;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
                got.first_seen    = res_bus.first_seen;
                got.forward_done  = res_bus.forward_done;
                got.forward_count = res_bus.forward_count;
                got.inverse_done  = res_bus.inverse_done;
                got.inverse_count = res_bus.inverse_count;
                if (!ledger.check_update(got, msg))
                    report_mismatch(msg);
            end
            if (hold_request) begin
                // hold off so the block backs up into its input
                res_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                res_bus.ready <= 1'b1;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    initial begin : stimulus
        t_visit v;
        ledger             = new();
        mismatches         = 0;
        hold_request       = 1'b0;
        src_idle_pct       = 21;
        sink_idle_pct      = 66;
        i_rst_n            = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        evt_bus.valid      = 1'b0;
        evt_bus.user_id    = '0;
        evt_bus.item_id    = '0;
        evt_bus.item_label = '0;
        evt_bus.eval_flag  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_visit(t_visit'{10'd0, 8'd0, 8'd0, 1'b0});
        send_visit(t_visit'{10'd1023, 8'd255, 8'd255, 1'b1});
        send_visit(t_visit'{10'd0, 8'd255, 8'd0, 1'b0});
        send_visit(t_visit'{10'd1023, 8'd255, 8'd255, 1'b1});
        send_visit(t_visit'{10'd0, 8'd255, 8'd170, 1'b1});
        evt_bus.valid <= 1'b0;
        wait_drained();

        // same cell hit by both directions
        apply_settings(MODE_SYMMETRIC, 1'b0, 1'b0);
        send_visit(t_visit'{10'd5, 8'd7, 8'd85, 1'b1});
        send_visit(t_visit'{10'd5, 8'd7, 8'd85, 1'b0});
        send_visit(t_visit'{10'd5, 8'd9, 8'd85, 1'b1});
        send_visit(t_visit'{10'd0, 8'd0, 8'd0, 1'b1});
        evt_bus.valid <= 1'b0;
        wait_drained();

        apply_settings(MODE_INVERTED, 1'b1, 1'b1);
        send_visit(t_visit'{10'd5, 8'd7, 8'd200, 1'b0});
        send_visit(t_visit'{10'd5, 8'd8, 8'd201, 1'b1});
        evt_bus.valid <= 1'b0;
        wait_drained();

        apply_settings(MODE_SYMMETRIC, 1'b1, 1'b0);
        send_visit(t_visit'{10'd5, 8'd8, 8'd201, 1'b0});
        evt_bus.valid <= 1'b0;
        wait_drained();

        apply_settings(MODE_RECORD_ONLY, 1'b0, 1'b0);
        send_visit(t_visit'{10'd5, 8'd1, 8'd2, 1'b1});
        send_visit(t_visit'{10'd7, 8'd4, 8'd4, 1'b1});
        send_visit(t_visit'{10'd5, 8'd2, 8'd3, 1'b1});
        evt_bus.valid <= 1'b0;
        wait_drained();

        apply_settings(MODE_NORMAL, 1'b0, 1'b1);
        send_visit(t_visit'{10'd5, 8'd6, 8'd0, 1'b0});
        send_visit(t_visit'{10'd5, 8'd6, 8'd0, 1'b1});
        evt_bus.valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 3) begin
                src_idle_pct  = 21;
                sink_idle_pct = 66;
            end else if (p < 6) begin
                src_idle_pct  = 66;
                sink_idle_pct = 21;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            apply_settings(PHASE_MODE[p], PHASE_LABELS[p], PHASE_FILTER[p]);
            if (p == PRESS_PHASE)
                hold_request = 1'b1;
            repeat (PHASE_BEATS) begin
                // mostly a small pool of users and items so transitions repeat
                v.user_id    = ($urandom_range(99) < 80)
                             ? USER_ID_W'($urandom_range(15))
                             : USER_ID_W'($urandom_range(N_USERS - 1));
                v.item_id    = ($urandom_range(99) < 70)
                             ? ITEM_ID_W'($urandom_range(7))
                             : ITEM_ID_W'($urandom_range(N_ITEMS - 1));
                v.item_label = ($urandom_range(99) < 60)
                             ? {1'b0, v.item_id[7:1]}
                             : ITEM_ID_W'($urandom_range(N_ITEMS - 1));
                v.eval_flag  = ($urandom_range(99) < 75);
                send_visit(v);
            end
            evt_bus.valid <= 1'b0;
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
hdl/tcu_pkg.sv
hdl/tcu_if.sv
hdl/tcu_wrap.sv
hdl/transition_count_updater.sv
tb/transition_count_updater_tb.sv
